/* rtl/mss_pkg.sv */
// Shared types, constants and helpers for the five-stage hazard and execute step.
// No dependencies; every other file imports this package.

package mss_pkg;

	localparam int NUM_REGS  = 32;
	localparam int MEM_WORDS = 32;
	localparam int REG_AW    = $clog2(NUM_REGS);
	localparam int MEM_AW    = $clog2(MEM_WORDS);

	typedef logic [31:0] word_t;
	typedef logic [REG_AW-1:0] reg_idx_t;
	typedef logic [MEM_AW-1:0] mem_idx_t;

	localparam word_t RESET_WORD = 32'd1;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_LW   = 3'd2,
		OP_SW   = 3'd3,
		OP_BEQ  = 3'd4,
		OP_NONE = 3'd7
	} op_t;

	localparam logic [1:0] STALL_NONE = 2'd0;
	localparam logic [1:0] STALL_ONE  = 2'd1;
	localparam logic [1:0] STALL_TWO  = 2'd2;

	typedef struct packed {
		op_t      prev_op;
		reg_idx_t prev_dest;
		mem_idx_t prev_midx;
		op_t      older_op;
		reg_idx_t older_dest;
	} hist_t;

	typedef struct packed {
		logic     en;
		reg_idx_t addr;
		word_t    data;
	} reg_wr_t;

	typedef struct packed {
		logic     en;
		mem_idx_t idx;
		word_t    data;
	} mem_wr_t;

	function automatic op_t decode_op(input logic [2:0] code);
		op_t op;
		case (code)
			OP_ADD: op = OP_ADD;
			OP_SUB: op = OP_SUB;
			OP_LW:  op = OP_LW;
			OP_SW:  op = OP_SW;
			OP_BEQ: op = OP_BEQ;
			default: op = OP_NONE;
		endcase
		return op;
	endfunction

	function automatic logic writes_dest(input op_t op);
		return op inside {OP_ADD, OP_SUB, OP_LW};
	endfunction

	// base + offset/4 (toward zero), wrapped to the memory depth
	function automatic mem_idx_t word_index(input word_t base, input logic signed [15:0] off);
		logic     round_up;
		mem_idx_t q;
		round_up = off[15] & (|off[1:0]);
		q = off[MEM_AW+1:2] + mem_idx_t'(round_up);
		return base[MEM_AW-1:0] + q;
	endfunction

endpackage

/* rtl/mss_regfile.sv */
// Register file: one write port, two read ports with registered read data.
// Per-entry valid bits give the reset contents. Depends on mss_pkg.

module mss_regfile (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  mss_pkg::reg_idx_t rd_addr_a,
	input  mss_pkg::reg_idx_t rd_addr_b,
	input  mss_pkg::reg_wr_t  wr,
	output mss_pkg::word_t    rd_data_a,
	output mss_pkg::word_t    rd_data_b
);
	import mss_pkg::*;

	word_t                 mem_q [NUM_REGS];
	logic [NUM_REGS-1:0]   valid_q;
	word_t                 rd_a_q;
	word_t                 rd_b_q;
	word_t                 init_a;
	word_t                 init_b;

	assign init_a = (rd_addr_a == '0) ? '0 : RESET_WORD;
	assign init_b = (rd_addr_b == '0) ? '0 : RESET_WORD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= valid_q[rd_addr_a] ? mem_q[rd_addr_a] : init_a;
			rd_b_q <= valid_q[rd_addr_b] ? mem_q[rd_addr_b] : init_b;
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

/* rtl/mss_dmem.sv */
// Data memory: word registers reset to one, asynchronous read, one write port.
// Depends on mss_pkg.

module mss_dmem (
	input  logic              clk,
	input  logic              arst_n,
	input  mss_pkg::mem_idx_t rd_idx,
	input  mss_pkg::mem_wr_t  wr,
	output mss_pkg::word_t    rd_data
);
	import mss_pkg::*;

	word_t mem_q [MEM_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MEM_WORDS; i++) begin
				mem_q[i] <= RESET_WORD;
			end
		end else if (wr.en) begin
			mem_q[wr.idx] <= wr.data;
		end
	end

	assign rd_data = mem_q[rd_idx];

endmodule

/* rtl/mss_hazard.sv */
// Stall-cycle rules for a non-forwarding five-stage pipeline.
// Uses the last two instructions' history; depends on mss_pkg.

module mss_hazard (
	input  mss_pkg::op_t      op,
	input  mss_pkg::reg_idx_t r1,
	input  mss_pkg::reg_idx_t r2,
	input  mss_pkg::reg_idx_t r3,
	input  mss_pkg::mem_idx_t midx,
	input  mss_pkg::hist_t    hist,
	output logic [1:0]        stall_cycles
);
	import mss_pkg::*;

	logic pw;
	logic ow;

	assign pw = writes_dest(hist.prev_op);
	assign ow = writes_dest(hist.older_op);

	always_comb begin
		stall_cycles = STALL_NONE;
		case (op)
			OP_ADD, OP_SUB: begin
				if (pw && (hist.prev_dest == r2 || hist.prev_dest == r3)) stall_cycles = STALL_TWO;
			end
			OP_LW: begin
				if (pw && hist.prev_dest == r2) stall_cycles = STALL_TWO;
				else if (hist.prev_op == OP_SW && hist.prev_midx == midx) stall_cycles = STALL_ONE;
			end
			OP_SW: begin
				if (pw && (hist.prev_dest == r1 || hist.prev_dest == r2)) stall_cycles = STALL_TWO;
			end
			OP_BEQ: begin
				if (pw) begin
					if (hist.prev_dest == r1 || hist.prev_dest == r2) stall_cycles = STALL_TWO;
					else if (ow && (hist.older_dest == r1 || hist.older_dest == r2))
						stall_cycles = STALL_ONE;
				end
			end
			default: stall_cycles = STALL_NONE;
		endcase
	end

endmodule

/* rtl/mips_subset_pipeline_step_top.sv */
// Top level of the add/sub/lw/sw/beq hazard and execute step.
// Depends on mss_pkg, mss_regfile, mss_dmem and mss_hazard.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid / in_stall  | cmd, first_reg, second_reg, third_reg, byte_offset
//   result  | out       | out_valid / out_stall| stall_cycles .. mem_index
//
// One instruction per cycle sustained while out_stall is low. On acceptance the register
// file is read into its output register; the hazard check, execute and state update then
// run, and the result register is loaded, which out_stall can hold off.
// Reset clears the pipeline, history, squash flag and register-file valid bits;
// data memory words return to one. No clearing pass.
// A stalled result register holds the instruction stage, which then stalls the input.

module mips_subset_pipeline_step_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [4:0]         first_reg,
	input  logic [4:0]         second_reg,
	input  logic [4:0]         third_reg,
	input  logic signed [15:0] byte_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         stall_cycles,
	output logic               squashed,
	output logic               branch_taken,
	output logic signed [15:0] branch_delta,
	output logic               reg_write,
	output logic [4:0]         write_reg,
	output logic signed [31:0] write_value,
	output logic               mem_write,
	output logic [4:0]         mem_index
);
	import mss_pkg::*;

	logic              accept;
	logic              advance;
	reg_idx_t          rd_addr_b;
	logic              cmd_is_alu;

	logic              valid_s1;
	op_t               op_s1;
	reg_idx_t          r1_s1;
	reg_idx_t          r2_s1;
	reg_idx_t          r3_s1;
	logic signed [15:0] off_s1;
	reg_idx_t          rb_s1;

	word_t             rf_a;
	word_t             rf_b;
	word_t             val_a;
	word_t             val_b;
	reg_wr_t           rf_wr;
	reg_wr_t           last_wr_q;
	mem_wr_t           dm_wr;
	word_t             dm_rd;

	hist_t             hist_q;
	logic              squash_q;
	logic [1:0]        hz_stall;

	mem_idx_t          midx_c;
	logic [1:0]        stall_c;
	logic              taken_c;
	logic              rw_c;
	logic              mw_c;
	word_t             wval_c;
	op_t               op_eff;

	logic              valid_s2;
	logic [1:0]        stall_s2;
	logic              squashed_s2;
	logic              taken_s2;
	logic [15:0]       delta_s2;
	logic              rw_s2;
	reg_idx_t          wreg_s2;
	word_t             wval_s2;
	logic              mw_s2;
	mem_idx_t          midx_s2;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign cmd_is_alu = (cmd == OP_ADD) || (cmd == OP_SUB);
	assign rd_addr_b  = cmd_is_alu ? third_reg : first_reg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= decode_op(cmd);
			r1_s1  <= first_reg;
			r2_s1  <= second_reg;
			r3_s1  <= third_reg;
			off_s1 <= byte_offset;
			rb_s1  <= rd_addr_b;
		end
	end

	mss_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (second_reg),
		.rd_addr_b (rd_addr_b),
		.wr        (rf_wr),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b)
	);

	// forward the latest write, which may have landed on the read edge
	assign val_a = (last_wr_q.en && last_wr_q.addr == r2_s1) ? last_wr_q.data : rf_a;
	assign val_b = (last_wr_q.en && last_wr_q.addr == rb_s1) ? last_wr_q.data : rf_b;

	assign midx_c = (!squash_q && (op_s1 == OP_LW || op_s1 == OP_SW)) ?
		word_index(val_a, off_s1) : '0;

	mss_dmem u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (midx_c),
		.wr      (dm_wr),
		.rd_data (dm_rd)
	);

	mss_hazard u_hazard (
		.op           (op_s1),
		.r1           (r1_s1),
		.r2           (r2_s1),
		.r3           (r3_s1),
		.midx         (midx_c),
		.hist         (hist_q),
		.stall_cycles (hz_stall)
	);

	always_comb begin
		taken_c = 1'b0;
		rw_c    = 1'b0;
		mw_c    = 1'b0;
		wval_c  = '0;
		stall_c = STALL_NONE;
		op_eff  = OP_NONE;
		if (!squash_q) begin
			op_eff  = op_s1;
			stall_c = hz_stall;
			case (op_s1)
				OP_ADD: begin
					rw_c   = 1'b1;
					wval_c = val_a + val_b;
				end
				OP_SUB: begin
					rw_c   = 1'b1;
					wval_c = val_a - val_b;
				end
				OP_LW: begin
					rw_c   = 1'b1;
					wval_c = dm_rd;
				end
				OP_SW: mw_c = 1'b1;
				OP_BEQ: taken_c = (val_a == val_b);
				default: stall_c = STALL_NONE;
			endcase
			// drop writes to register zero
			if (rw_c && r1_s1 == '0) begin
				rw_c   = 1'b0;
				wval_c = '0;
			end
		end
	end

	assign rf_wr.en   = advance && rw_c;
	assign rf_wr.addr = r1_s1;
	assign rf_wr.data = wval_c;

	assign dm_wr.en   = advance && mw_c;
	assign dm_wr.idx  = midx_c;
	assign dm_wr.data = val_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_wr_q <= '0;
		end else if (rf_wr.en) begin
			last_wr_q <= rf_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q   <= '{prev_op: OP_NONE, prev_dest: '0, prev_midx: '0,
				older_op: OP_NONE, older_dest: '0};
			squash_q <= 1'b0;
		end else if (advance) begin
			hist_q.older_op   <= hist_q.prev_op;
			hist_q.older_dest <= hist_q.prev_dest;
			hist_q.prev_op    <= op_eff;
			hist_q.prev_dest  <= writes_dest(op_eff) ? r1_s1 : '0;
			hist_q.prev_midx  <= midx_c;
			squash_q          <= taken_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stall_s2    <= stall_c;
			squashed_s2 <= squash_q;
			taken_s2    <= taken_c;
			delta_s2    <= taken_c ? off_s1 : '0;
			rw_s2       <= rw_c;
			wreg_s2     <= rw_c ? r1_s1 : '0;
			wval_s2     <= wval_c;
			mw_s2       <= mw_c;
			midx_s2     <= midx_c;
		end
	end

	assign out_valid    = valid_s2;
	assign stall_cycles = stall_s2;
	assign squashed     = squashed_s2;
	assign branch_taken = taken_s2;
	assign branch_delta = delta_s2;
	assign reg_write    = rw_s2;
	assign write_reg    = wreg_s2;
	assign write_value  = wval_s2;
	assign mem_write    = mw_s2;
	assign mem_index    = midx_s2;

	a_r0_never_written: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr.en |-> rf_wr.addr != '0)
		else $error("register zero written");

	a_taken_sets_squash: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && taken_c) |=> squash_q)
		else $error("taken branch did not arm squash");

	a_squash_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && squashed_s2) |-> !(rw_s2 || mw_s2 || taken_s2))
		else $error("squashed transaction has side effects");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked result");

endmodule
